// File: design/tpts_pkg.sv
// ----------------------------------------------------------------------------
// tpts_pkg
// shared types and constants of the timed priority task scheduler
// ----------------------------------------------------------------------------
package tpts_pkg;

    localparam int POS_W   = 6;
    localparam int TIME_W  = 31;
    localparam int DUE_W   = 32;
    localparam logic [TIME_W-1:0] TIME_MAX = 31'h7FFF_FFFF;

    localparam logic [3:0] CMD_TICK     = 4'd0;
    localparam logic [3:0] CMD_SCHEDULE = 4'd1;
    localparam logic [3:0] CMD_RUN      = 4'd2;
    localparam logic [3:0] CMD_DELAY    = 4'd3;
    localparam logic [3:0] CMD_REPEAT   = 4'd4;
    localparam logic [3:0] CMD_STOP     = 4'd5;
    localparam logic [3:0] CMD_SUSPEND  = 4'd6;
    localparam logic [3:0] CMD_RESUME   = 4'd7;
    localparam logic [3:0] CMD_SET_PRIO = 4'd8;
    localparam logic [3:0] CMD_REPLACE  = 4'd9;

    localparam logic [1:0] SLEEP_NONE  = 2'd0;
    localparam logic [1:0] SLEEP_IDLE  = 2'd1;
    localparam logic [1:0] SLEEP_POWER = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } state_t;

    // search record handed from cell to cell
    typedef struct packed {
        logic              fa_found;
        logic [POS_W-1:0]  fa_pos;
        logic              free_found;
        logic [POS_W-1:0]  free_pos;
        logic              sel_found;
        logic [POS_W-1:0]  sel_pos;
        logic [7:0]        best;
        logic [POS_W-1:0]  count;
        logic [7:0]        sel_handle;
        logic              sel_repeat;
        logic [15:0]       sel_reload;
    } scan_rec_t;

    // what the search looks for
    typedef struct packed {
        logic [7:0]        handle;
        logic [TIME_W-1:0] now;
    } scan_ctx_t;

    // write to one slot, or tick to all
    typedef struct packed {
        logic              tick;
        logic              wrap;
        logic              en;
        logic [POS_W-1:0]  slot;
        logic              set_handle;
        logic [7:0]        handle;
        logic              set_active;
        logic              active;
        logic              set_susp;
        logic              susp;
        logic              set_due;
        logic [DUE_W-1:0]  due;
        logic              set_repeat;
        logic              repeat_flag;
        logic              set_reload;
        logic [15:0]       reload;
        logic              set_prio;
        logic [7:0]        prio;
    } slot_upd_t;

endpackage

// File: design/tpts_cell.sv
// ----------------------------------------------------------------------------
// tpts_cell
// one task slot: holds its state and updates the passing search record
// ----------------------------------------------------------------------------
module tpts_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tpts_pkg::POS_W-1:0]  slot_index,
    input  tpts_pkg::scan_ctx_t         ctx,
    input  tpts_pkg::scan_rec_t         rec_in,
    output tpts_pkg::scan_rec_t         rec_out,
    input  tpts_pkg::slot_upd_t         upd
);

    logic                        active_reg;
    logic                        susp_reg;
    logic                        repeat_reg;
    logic [15:0]                 reload_reg;
    logic [7:0]                  prio_reg;
    logic [tpts_pkg::DUE_W-1:0]  due_reg;
    logic [7:0]                  handle_reg;
    tpts_pkg::scan_rec_t         rec_reg;
    tpts_pkg::scan_rec_t         rec_next;
    logic                        hit;
    logic [tpts_pkg::DUE_W-1:0]  due_tick;

    assign hit = upd.en && (upd.slot == slot_index);

    always_comb
    begin
        rec_next = rec_in;
        if (active_reg && (handle_reg == ctx.handle) && !rec_in.fa_found)
        begin
            rec_next.fa_found = 1'b1;
            rec_next.fa_pos   = slot_index;
        end
        if (!active_reg)
        begin
            rec_next.free_found = 1'b1;
            rec_next.free_pos   = slot_index;
        end
        if (active_reg)
        begin
            rec_next.count = rec_in.count + 1'b1;
            if (!susp_reg && (due_reg <= {1'b0, ctx.now}) && (prio_reg >= rec_in.best))
            begin
                rec_next.sel_found  = 1'b1;
                rec_next.sel_pos    = slot_index;
                rec_next.best       = prio_reg;
                rec_next.sel_handle = handle_reg;
                rec_next.sel_repeat = repeat_reg;
                rec_next.sel_reload = reload_reg;
            end
        end
    end

    assign rec_out = rec_reg;

    // wrap clears the top bit, then suspended slots slide by one tick
    always_comb
    begin
        due_tick = due_reg;
        if (upd.wrap)
        begin
            due_tick[tpts_pkg::DUE_W-1] = 1'b0;
        end
        if (susp_reg)
        begin
            due_tick = due_tick + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            susp_reg   <= 1'b0;
            repeat_reg <= 1'b0;
            reload_reg <= '0;
            prio_reg   <= '0;
        end
        else if (hit)
        begin
            if (upd.set_active) active_reg <= upd.active;
            if (upd.set_susp)   susp_reg   <= upd.susp;
            if (upd.set_repeat) repeat_reg <= upd.repeat_flag;
            if (upd.set_reload) reload_reg <= upd.reload;
            if (upd.set_prio)   prio_reg   <= upd.prio;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        if (upd.tick && active_reg)
        begin
            due_reg <= due_tick;
        end
        else if (hit)
        begin
            if (upd.set_due)    due_reg    <= upd.due;
            if (upd.set_handle) handle_reg <= upd.handle;
        end
    end

endmodule

// File: design/timed_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// timed_priority_task_scheduler
// task slot table with tick, schedule and per-task commands
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    command, use_current, task_handle, new_handle,
//                                  timeout, priority_req, in_interrupt
//  out      out_valid / out_ready  task_valid, run_handle, run_slot, sleep_mode,
//                                  active_count, accepted
//  cfg      apb psel/penable       power-save enable at byte address 0
//
//  each transaction is latched, then the search record ripples through the row
//  of slot cells, then the result is applied;
//  one transaction at a time; in_ready is high only while idle
//  a stalled result holds the block in its apply step until out_ready
//  reset clears slot flags, time and the current slot; no clearing pass
// ----------------------------------------------------------------------------
module timed_priority_task_scheduler
#(
    parameter int TASK_SLOTS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    // input transaction
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [3:0]   command,
    input  logic         use_current,
    input  logic [7:0]   task_handle,
    input  logic [7:0]   new_handle,
    input  logic [15:0]  timeout,
    input  logic [7:0]   priority_req,
    input  logic         in_interrupt,
    // result transaction
    output logic         out_valid,
    input  logic         out_ready,
    output logic         task_valid,
    output logic [7:0]   run_handle,
    output logic [3:0]   run_slot,
    output logic [1:0]   sleep_mode,
    output logic [3:0]   active_count,
    output logic         accepted,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int PW = tpts_pkg::POS_W;
    localparam logic [PW-1:0] IDLE_POS = PW'(TASK_SLOTS);
    localparam logic [PW-1:0] LAST_CNT = PW'(TASK_SLOTS - 1);

    tpts_pkg::state_t              state_reg, state_next;
    logic [PW-1:0]                 cnt_reg, cnt_next;
    logic [tpts_pkg::TIME_W-1:0]   time_reg, time_next;
    logic [PW-1:0]                 cur_reg, cur_next;
    logic                          psave_en_reg;

    // latched transaction
    logic [3:0]   cmd_reg;
    logic         use_cur_reg;
    logic [7:0]   handle_reg;
    logic [7:0]   new_handle_reg;
    logic [15:0]  timeout_reg;
    logic [7:0]   prio_reg;
    logic         irq_reg;

    // result register
    logic         out_valid_reg;
    logic         task_valid_reg, task_valid_next;
    logic [7:0]   run_handle_reg, run_handle_next;
    logic [3:0]   run_slot_reg, run_slot_next;
    logic [1:0]   sleep_reg, sleep_next;
    logic [3:0]   count_reg, count_next;
    logic         accepted_reg, accepted_next;

    tpts_pkg::scan_ctx_t  ctx;
    tpts_pkg::scan_rec_t  recs [TASK_SLOTS+1];
    tpts_pkg::scan_rec_t  fin;
    tpts_pkg::slot_upd_t  upd;

    logic take_in, out_free, by_cur;
    logic [PW-1:0] pos;

    assign take_in  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == tpts_pkg::S_IDLE);

    // apb: single register, always ready
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'd0, psave_en_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psave_en_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            psave_en_reg <= pwdata[0];
        end
    end

    // row of slot cells, the search record moves one cell per cycle
    assign ctx.handle = handle_reg;
    assign ctx.now    = time_reg;
    assign recs[0]    = '{fa_pos: IDLE_POS, free_pos: IDLE_POS, sel_pos: IDLE_POS,
                          default: '0};
    assign fin        = recs[TASK_SLOTS];

    for (genvar g = 0; g < TASK_SLOTS; g++)
    begin : g_cell
        tpts_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .slot_index (PW'(g)),
            .ctx        (ctx),
            .rec_in     (recs[g]),
            .rec_out    (recs[g+1]),
            .upd        (upd)
        );
    end

    // slot chosen for a per-task command
    always_comb
    begin
        by_cur = use_cur_reg && (cmd_reg != tpts_pkg::CMD_REPLACE);
        pos    = IDLE_POS;
        if (by_cur)
        begin
            if (!irq_reg && (cur_reg != IDLE_POS)) pos = cur_reg;
        end
        else if (cmd_reg <= tpts_pkg::CMD_REPEAT)
        begin
            if (fin.fa_found)        pos = fin.fa_pos;
            else if (fin.free_found) pos = fin.free_pos;
        end
        else if (fin.fa_found)
        begin
            pos = fin.fa_pos;
        end
    end

    // sequencer: latch, ripple, apply
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        time_next       = time_reg;
        cur_next        = cur_reg;
        upd             = '0;
        task_valid_next = 1'b0;
        run_handle_next = 8'd0;
        run_slot_next   = 4'(IDLE_POS);
        sleep_next      = tpts_pkg::SLEEP_NONE;
        count_next      = 4'd0;
        accepted_next   = 1'b0;
        case (state_reg)
            tpts_pkg::S_IDLE:
            begin
                if (take_in)
                begin
                    state_next = tpts_pkg::S_SCAN;
                    cnt_next   = '0;
                end
            end
            tpts_pkg::S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT) state_next = tpts_pkg::S_APPLY;
            end
            tpts_pkg::S_APPLY:
            begin
                if (out_free)
                begin
                    state_next = tpts_pkg::S_IDLE;
                    case (cmd_reg)
                        tpts_pkg::CMD_TICK:
                        begin
                            upd.tick      = 1'b1;
                            upd.wrap      = (time_reg == tpts_pkg::TIME_MAX);
                            time_next     = upd.wrap ? '0 : time_reg + 1'b1;
                            accepted_next = 1'b1;
                        end
                        tpts_pkg::CMD_SCHEDULE:
                        begin
                            accepted_next = 1'b1;
                            count_next    = 4'(fin.count);
                            if (fin.sel_found)
                            begin
                                cur_next        = fin.sel_pos;
                                upd.en          = 1'b1;
                                upd.slot        = fin.sel_pos;
                                upd.set_due     = fin.sel_repeat;
                                upd.due         = {1'b0, time_reg} + 32'(fin.sel_reload);
                                upd.set_active  = !fin.sel_repeat;
                                upd.active      = 1'b0;
                                task_valid_next = 1'b1;
                                run_handle_next = fin.sel_handle;
                                run_slot_next   = 4'(fin.sel_pos);
                            end
                            else
                            begin
                                cur_next   = IDLE_POS;
                                sleep_next = (psave_en_reg && (fin.count == '0))
                                           ? tpts_pkg::SLEEP_POWER : tpts_pkg::SLEEP_IDLE;
                            end
                        end
                        tpts_pkg::CMD_RUN, tpts_pkg::CMD_DELAY, tpts_pkg::CMD_REPEAT:
                        begin
                            if (pos != IDLE_POS)
                            begin
                                accepted_next  = 1'b1;
                                upd.en         = 1'b1;
                                upd.slot       = pos;
                                upd.set_handle = !by_cur;
                                upd.handle     = handle_reg;
                                upd.set_active = 1'b1;
                                upd.active     = 1'b1;
                                upd.set_susp   = 1'b1;
                                upd.susp       = 1'b0;
                                upd.set_due    = 1'b1;
                                upd.due        = {1'b0, time_reg}
                                               + ((cmd_reg == tpts_pkg::CMD_RUN)
                                                  ? 32'd0 : 32'(timeout_reg));
                                upd.set_repeat = (cmd_reg != tpts_pkg::CMD_RUN);
                                upd.repeat_flag = (cmd_reg == tpts_pkg::CMD_REPEAT);
                                upd.set_reload = (cmd_reg == tpts_pkg::CMD_REPEAT) && !by_cur;
                                upd.reload     = timeout_reg;
                            end
                        end
                        tpts_pkg::CMD_STOP, tpts_pkg::CMD_SUSPEND, tpts_pkg::CMD_RESUME,
                        tpts_pkg::CMD_SET_PRIO, tpts_pkg::CMD_REPLACE:
                        begin
                            if (pos != IDLE_POS)
                            begin
                                accepted_next  = 1'b1;
                                upd.en         = 1'b1;
                                upd.slot       = pos;
                                upd.set_active = (cmd_reg == tpts_pkg::CMD_STOP);
                                upd.active     = 1'b0;
                                upd.set_susp   = (cmd_reg == tpts_pkg::CMD_SUSPEND)
                                              || (cmd_reg == tpts_pkg::CMD_RESUME);
                                upd.susp       = (cmd_reg == tpts_pkg::CMD_SUSPEND);
                                upd.set_prio   = (cmd_reg == tpts_pkg::CMD_SET_PRIO);
                                upd.prio       = prio_reg;
                                upd.set_handle = (cmd_reg == tpts_pkg::CMD_REPLACE);
                                upd.handle     = new_handle_reg;
                            end
                        end
                        default:
                        begin
                            accepted_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = tpts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpts_pkg::S_IDLE;
            cnt_reg       <= '0;
            time_reg      <= '0;
            cur_reg       <= IDLE_POS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            time_reg  <= time_next;
            cur_reg   <= cur_next;
            if ((state_reg == tpts_pkg::S_APPLY) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            cmd_reg        <= command;
            use_cur_reg    <= use_current;
            handle_reg     <= task_handle;
            new_handle_reg <= new_handle;
            timeout_reg    <= timeout;
            prio_reg       <= priority_req;
            irq_reg        <= in_interrupt;
        end
        if ((state_reg == tpts_pkg::S_APPLY) && out_free)
        begin
            task_valid_reg <= task_valid_next;
            run_handle_reg <= run_handle_next;
            run_slot_reg   <= run_slot_next;
            sleep_reg      <= sleep_next;
            count_reg      <= count_next;
            accepted_reg   <= accepted_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign task_valid   = task_valid_reg;
    assign run_handle   = run_handle_reg;
    assign run_slot     = run_slot_reg;
    assign sleep_mode   = sleep_reg;
    assign active_count = count_reg;
    assign accepted     = accepted_reg;

    // checks
    a_sel_no_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && task_valid |-> sleep_mode == tpts_pkg::SLEEP_NONE)
        else $error("task picked with sleep mode");
    a_no_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !task_valid |-> run_handle == 8'd0)
        else $error("handle reported without a task");
    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= IDLE_POS)
        else $error("current slot out of range");
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tpts_pkg::S_SCAN |=> !in_ready)
        else $error("input taken during search");

endmodule
